// ----- rtl/wgne_pkg.sv -----
// wgne_pkg: shared types and constants of the weighted grid neighbour expander
// no dependencies; used by the interfaces and every module in rtl

package wgne_pkg;

  localparam int ID_FIELD_W  = 24;
  localparam int WEIGHT_W    = 8;
  localparam int DIR_BITS    = 3;
  localparam int COST_W      = 17;
  localparam int STRIDE_W    = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_DIRS    = 8;

  localparam int DEF_ID_BITS        = 24;
  localparam int DEF_COST_FRAC_BITS = 8;

  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RESET = 16'd3;
  localparam logic [COST_W-1:0]   COST_MAX         = 17'h1FFFF;

  // round(sqrt(2) * 2^32)
  localparam int                  ROOT2_W   = 33;
  localparam logic [ROOT2_W-1:0]  ROOT2_Q32 = 33'd6074001000;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_ROW_STRIDE = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_t;

  // clockwise from north
  typedef enum logic [DIR_BITS-1:0] {
    DIR_N  = 3'd0,
    DIR_NE = 3'd1,
    DIR_E  = 3'd2,
    DIR_SE = 3'd3,
    DIR_S  = 3'd4,
    DIR_SW = 3'd5,
    DIR_W  = 3'd6,
    DIR_NW = 3'd7
  } dir_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] nw;
    logic [WEIGHT_W-1:0] n;
    logic [WEIGHT_W-1:0] ne;
    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W-1:0] c;
    logic [WEIGHT_W-1:0] e;
    logic [WEIGHT_W-1:0] sw;
    logic [WEIGHT_W-1:0] s;
    logic [WEIGHT_W-1:0] se;
  } nbhd_t;

endpackage

// ----- rtl/wgne_in_if.sv -----
// wgne_in_if: input channel, one cell id with its 3x3 weights per transfer
// depends on wgne_pkg

interface wgne_in_if;
  logic                           valid;
  logic                           ready;
  logic [wgne_pkg::ID_FIELD_W-1:0] center_id;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_nw;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_n;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_ne;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_w;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_c;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_e;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_sw;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_s;
  logic [wgne_pkg::WEIGHT_W-1:0]   weight_se;

  modport source (
    output valid, center_id, weight_nw, weight_n, weight_ne, weight_w, weight_c,
           weight_e, weight_sw, weight_s, weight_se,
    input  ready
  );

  modport sink (
    input  valid, center_id, weight_nw, weight_n, weight_ne, weight_w, weight_c,
           weight_e, weight_sw, weight_s, weight_se,
    output ready
  );
endinterface

// ----- rtl/wgne_out_if.sv -----
// wgne_out_if: result channel, one reachable neighbour per transfer
// depends on wgne_pkg

interface wgne_out_if;
  logic                            valid;
  logic                            ready;
  logic [wgne_pkg::ID_FIELD_W-1:0] neighbour_id;
  logic [wgne_pkg::DIR_BITS-1:0]   direction;
  logic [wgne_pkg::COST_W-1:0]     move_cost;
  logic                            last;

  modport source (
    output valid, neighbour_id, direction, move_cost, last,
    input  ready
  );

  modport sink (
    input  valid, neighbour_id, direction, move_cost, last,
    output ready
  );
endinterface

// ----- rtl/wgne_cfg_regs.sv -----
// wgne_cfg_regs: apb-style register port holding the row stride
// depends on wgne_pkg

module wgne_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wgne_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wgne_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wgne_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output logic [wgne_pkg::STRIDE_W-1:0]     row_stride
);

  logic [wgne_pkg::STRIDE_W-1:0] row_stride_r;
  logic [wgne_pkg::STRIDE_W-1:0] row_stride_nxt;
  wgne_pkg::reg_idx_t            reg_idx;
  logic                          wr_en;

  assign reg_idx    = wgne_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    row_stride_nxt = row_stride_r;
    if (wr_en && (reg_idx == wgne_pkg::REG_ROW_STRIDE)) begin
      row_stride_nxt = cfg_pwdata[wgne_pkg::STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r <= wgne_pkg::ROW_STRIDE_RESET;
    end else begin
      row_stride_r <= row_stride_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      wgne_pkg::REG_ROW_STRIDE:
        cfg_prdata = wgne_pkg::CFG_DATA_W'(row_stride_r);
      default:
        cfg_prdata = '0;
    endcase
  end

  assign row_stride = row_stride_r;

endmodule

// ----- rtl/wgne_succ.sv -----
// wgne_succ: id and move cost of one successor in a given direction
// depends on wgne_pkg; combinational, sits between the hold and result registers

module wgne_succ #(
  parameter int ID_BITS        = wgne_pkg::DEF_ID_BITS,
  parameter int COST_FRAC_BITS = wgne_pkg::DEF_COST_FRAC_BITS
) (
  input  logic [wgne_pkg::ID_FIELD_W-1:0] center_id,
  input  logic [wgne_pkg::STRIDE_W-1:0]   row_stride,
  input  wgne_pkg::nbhd_t                 nbhd,
  input  wgne_pkg::dir_t                  dir,
  output logic [wgne_pkg::ID_FIELD_W-1:0] neighbour_id,
  output logic [wgne_pkg::COST_W-1:0]     move_cost
);

  localparam int SUM_W  = wgne_pkg::WEIGHT_W + 2;
  localparam int PROD_W = SUM_W + wgne_pkg::ROOT2_W;
  localparam int RND_SH = 33 - COST_FRAC_BITS;
  localparam int DIAG_SH = 34 - COST_FRAC_BITS;
  localparam int STR_SH = COST_FRAC_BITS - 1;

  logic [ID_BITS-1:0]    c_w;
  logic [ID_BITS-1:0]    st_w;
  logic [ID_BITS-1:0]    vert;
  logic [ID_BITS-1:0]    id_w;
  logic                  is_diag;
  logic [wgne_pkg::WEIGHT_W-1:0] wa, wb, wc, wd;
  logic [SUM_W-1:0]      sum;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     cost_full;

  assign c_w  = ID_BITS'(center_id);
  assign st_w = ID_BITS'(row_stride);

  // row step, then column step, both wrapping at ID_BITS
  always_comb begin
    unique case (dir)
      wgne_pkg::DIR_N, wgne_pkg::DIR_NE, wgne_pkg::DIR_NW: vert = c_w - st_w;
      wgne_pkg::DIR_S, wgne_pkg::DIR_SE, wgne_pkg::DIR_SW: vert = c_w + st_w;
      default:                                             vert = c_w;
    endcase
    unique case (dir)
      wgne_pkg::DIR_NE, wgne_pkg::DIR_E, wgne_pkg::DIR_SE:
        id_w = vert + ID_BITS'(1);
      wgne_pkg::DIR_NW, wgne_pkg::DIR_W, wgne_pkg::DIR_SW:
        id_w = vert - ID_BITS'(1);
      default:
        id_w = vert;
    endcase
  end

  assign neighbour_id = wgne_pkg::ID_FIELD_W'(id_w);

  always_comb begin
    is_diag = 1'b0;
    wa = nbhd.c;
    wb = '0;
    wc = '0;
    wd = '0;
    unique case (dir)
      wgne_pkg::DIR_N:  wb = nbhd.n;
      wgne_pkg::DIR_E:  wb = nbhd.e;
      wgne_pkg::DIR_S:  wb = nbhd.s;
      wgne_pkg::DIR_W:  wb = nbhd.w;
      wgne_pkg::DIR_NE: begin
        is_diag = 1'b1;
        wb = nbhd.n; wc = nbhd.ne; wd = nbhd.e;
      end
      wgne_pkg::DIR_SE: begin
        is_diag = 1'b1;
        wb = nbhd.e; wc = nbhd.s; wd = nbhd.se;
      end
      wgne_pkg::DIR_SW: begin
        is_diag = 1'b1;
        wb = nbhd.w; wc = nbhd.sw; wd = nbhd.s;
      end
      default: begin
        is_diag = 1'b1;
        wb = nbhd.nw; wc = nbhd.n; wd = nbhd.w;
      end
    endcase
  end

  assign sum  = SUM_W'(wa) + SUM_W'(wb) + SUM_W'(wc) + SUM_W'(wd);
  // constant multiplier, sum is only ten bits
  assign prod = PROD_W'(sum) * PROD_W'(wgne_pkg::ROOT2_Q32);

  always_comb begin
    if (is_diag) begin
      cost_full = (prod + (PROD_W'(1) << RND_SH)) >> DIAG_SH;
    end else begin
      cost_full = PROD_W'(sum) << STR_SH;
    end
  end

  assign move_cost = (cost_full > PROD_W'(wgne_pkg::COST_MAX)) ? wgne_pkg::COST_MAX
                                                               : cost_full[wgne_pkg::COST_W-1:0];

endmodule

// ----- rtl/weighted_grid_neighbour_expander.sv -----
// weighted_grid_neighbour_expander: top level, hold register, picker, result register
// depends on wgne_pkg, wgne_in_if, wgne_out_if, wgne_cfg_regs, wgne_succ
//
// Usage:
//   in_ch carries one cell per transfer: its padded id and the nine terrain
//   weights of its 3x3 neighbourhood (weight 0 = blocked). out_ch carries one
//   reachable neighbour per transfer, clockwise from north, with its id,
//   direction and move cost; last marks the final neighbour of a cell. A cell
//   with no open neighbour is taken and yields no transfer at all.
//   The cfg_ port sets row_stride (byte address 0); write it only while idle.
// Flow:
//   a cell is held in the hold register, and one neighbour per cycle moves from
//   it into the result register while out_ch is not stalled; the first result
//   thus passes through the hold register and then the result register. A cell
//   stays in the hold register until its last reachable neighbour moves out; a
//   cell with none is dropped at its transfer and never occupies it. The next
//   cell is taken in the cycle its last neighbour moves out.
// Reset and stall:
//   rst_n (synchronous, active low) empties both registers and sets
//   row_stride to 3. When out_ch.ready is low the result register holds its
//   transfer, the hold register stops, and in_ch.ready drops once a cell waits.

module weighted_grid_neighbour_expander #(
  parameter int ID_BITS        = wgne_pkg::DEF_ID_BITS,
  parameter int COST_FRAC_BITS = wgne_pkg::DEF_COST_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wgne_in_if.sink                         in_ch,
  wgne_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wgne_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wgne_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wgne_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int ND = wgne_pkg::NUM_DIRS;

  logic [wgne_pkg::STRIDE_W-1:0]   row_stride;

  // hold register
  logic                            hold_vld_r, hold_vld_nxt;
  logic [ND-1:0]                   pend_r, pend_nxt;
  logic [wgne_pkg::ID_FIELD_W-1:0] hold_id_r;
  wgne_pkg::nbhd_t                 hold_nbhd_r;

  // result register
  logic                            out_vld_r, out_vld_nxt;
  logic [wgne_pkg::ID_FIELD_W-1:0] out_id_r;
  logic [wgne_pkg::DIR_BITS-1:0]   out_dir_r;
  logic [wgne_pkg::COST_W-1:0]     out_cost_r;
  logic                            out_last_r;

  wgne_pkg::nbhd_t                 in_nbhd;
  logic [ND-1:0]                   in_mask;
  logic                            in_xfer;
  logic                            out_free;
  logic                            advance;
  logic [wgne_pkg::DIR_BITS-1:0]   pick;
  logic [ND-1:0]                   pend_left;
  logic                            pick_last;
  logic [wgne_pkg::ID_FIELD_W-1:0] succ_id;
  logic [wgne_pkg::COST_W-1:0]     succ_cost;

  wgne_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .row_stride  (row_stride)
  );

  assign in_nbhd = '{nw: in_ch.weight_nw, n: in_ch.weight_n, ne: in_ch.weight_ne,
                     w: in_ch.weight_w, c: in_ch.weight_c, e: in_ch.weight_e,
                     sw: in_ch.weight_sw, s: in_ch.weight_s, se: in_ch.weight_se};

  // reachability; the centre weight never blocks
  always_comb begin
    in_mask = '0;
    in_mask[wgne_pkg::DIR_N]  = (in_nbhd.n != '0);
    in_mask[wgne_pkg::DIR_NE] = (in_nbhd.n != '0) && (in_nbhd.ne != '0) && (in_nbhd.e != '0);
    in_mask[wgne_pkg::DIR_E]  = (in_nbhd.e != '0);
    in_mask[wgne_pkg::DIR_SE] = (in_nbhd.e != '0) && (in_nbhd.s != '0) && (in_nbhd.se != '0);
    in_mask[wgne_pkg::DIR_S]  = (in_nbhd.s != '0);
    in_mask[wgne_pkg::DIR_SW] = (in_nbhd.w != '0) && (in_nbhd.sw != '0) && (in_nbhd.s != '0);
    in_mask[wgne_pkg::DIR_W]  = (in_nbhd.w != '0);
    in_mask[wgne_pkg::DIR_NW] = (in_nbhd.nw != '0) && (in_nbhd.n != '0) && (in_nbhd.w != '0);
  end

  // lowest pending direction goes first
  always_comb begin
    pick = '0;
    for (int i = ND - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        pick = wgne_pkg::DIR_BITS'(i);
      end
    end
  end

  always_comb begin
    pend_left       = pend_r;
    pend_left[pick] = 1'b0;
  end

  assign pick_last = (pend_left == '0);
  assign out_free  = !out_vld_r || out_ch.ready;
  assign advance   = hold_vld_r && out_free;
  assign in_ch.ready = !hold_vld_r || (advance && pick_last);
  assign in_xfer   = in_ch.valid && in_ch.ready;

  wgne_succ #(
    .ID_BITS        (ID_BITS),
    .COST_FRAC_BITS (COST_FRAC_BITS)
  ) u_succ (
    .center_id    (hold_id_r),
    .row_stride   (row_stride),
    .nbhd         (hold_nbhd_r),
    .dir          (wgne_pkg::dir_t'(pick)),
    .neighbour_id (succ_id),
    .move_cost    (succ_cost)
  );

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    pend_nxt     = pend_r;
    if (advance) begin
      pend_nxt = pend_left;
      if (pick_last) begin
        hold_vld_nxt = 1'b0;
      end
    end
    // a cell with nothing reachable is dropped on transfer
    if (in_xfer) begin
      hold_vld_nxt = (in_mask != '0);
      pend_nxt     = in_mask;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      out_vld_nxt = advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      pend_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      pend_r     <= pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_id_r   <= in_ch.center_id;
      hold_nbhd_r <= in_nbhd;
    end
    if (advance) begin
      out_id_r   <= succ_id;
      out_dir_r  <= pick;
      out_cost_r <= succ_cost;
      out_last_r <= pick_last;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.neighbour_id = out_id_r;
  assign out_ch.direction    = out_dir_r;
  assign out_ch.move_cost    = out_cost_r;
  assign out_ch.last         = out_last_r;

  // a held cell always has something left to send
  a_hold_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (pend_r != '0))
    else $error("hold register valid with no pending direction");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_vld_r |-> in_ch.ready)
    else $error("input stalled while hold register empty");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("moved neighbour did not reach result register");

  a_cell_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !pick_last) |=> (hold_vld_r && !in_ch.ready || hold_vld_r && out_free))
    else $error("cell left hold register before its last neighbour");

  a_pend_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !pick_last) |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("pending directions did not drop by one");

endmodule
